>>> rtl/hcs_pkg.sv
// Shared types and constants for the histogram contrast stretch unit.
`timescale 1ns / 1ps
`default_nettype none

package hcs_pkg;

  // Histogram geometry
  localparam int unsigned NBINS    = 256;
  localparam int unsigned BIN_W    = 8;    // bin / pixel index width
  localparam int unsigned BIDX_W   = 9;    // bin index plus "none" code
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CFG_W    = 17;   // min_count width
  localparam int unsigned DIV_CNT_W = 3;   // one quotient bit per step, 8 steps

  // Stream payload widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 32;

  // APB port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [0:0]  REG_MIN_COUNT = 1'b0;  // word index of min_count

  // Top of the stretch range
  localparam logic [PIX_W-1:0] TOPVAL = 8'd255;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_ACC = 2'd0,
    CMD_FIN = 2'd1,
    CMD_MAP = 2'd2,
    CMD_RSV = 2'd3
  } cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic acc_rd;      // read bin count for the accepted pixel
    logic acc_wr;      // write back incremented count
    logic map_rd;      // read stretch entry for the accepted pixel
    logic map_load;    // load map result into the output register
    logic fin_start;   // reset scan, divider and build counters
    logic scan_step;   // advance bin scan
    logic div_step;    // one step of 255 / span
    logic build_step;  // write one stretch entry
    logic fin_load;    // load bounds result, clear histogram
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic div_last;
    logic build_last;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

>>> rtl/hcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/hcs_ctrl.sv
// Controller state machine: sequences accumulate, map and finish items.
`timescale 1ns / 1ps
`default_nettype none

module hcs_ctrl
  import hcs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_tvalid_i,
  input  wire cmd_e     cmd_i,
  output logic          s_tready_o,
  input  wire ctl_sts_t sts_i,
  output ctl_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MAP,
    ST_SCAN,
    ST_DIV,
    ST_BUILD,
    ST_FIN
  } state_e;

  state_e   state_q, state_d;
  logic     rdy_q, rdy_d;
  logic     accept;
  ctl_cmd_t cmd;

  assign accept = rdy_q & s_tvalid_i;

  // Command decode and next state
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_ACC: begin
              cmd.acc_rd = 1'b1;
              state_d    = ST_ACC;
            end
            CMD_FIN: begin
              cmd.fin_start = 1'b1;
              state_d       = ST_SCAN;
            end
            CMD_MAP: begin
              cmd.map_rd = 1'b1;
              state_d    = ST_MAP;
            end
            CMD_RSV: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ACC: begin
        cmd.acc_wr = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_MAP: begin
        if (sts_i.out_free) begin
          cmd.map_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_BUILD;
        end
      end
      ST_BUILD: begin
        cmd.build_step = 1'b1;
        if (sts_i.build_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd.fin_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    rdy_d = (state_d == ST_IDLE);
  end

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= rdy_d;
    end
  end

  assign s_tready_o = rdy_q;
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

>>> rtl/hcs_dpath.sv
// Datapath: histogram and stretch table memories, scan, divider, table build, output register.
`timescale 1ns / 1ps
`default_nettype none

module hcs_dpath
  import hcs_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [PIX_W-1:0]     pixel_i,
  input  wire logic [CFG_W-1:0]     min_count_i,
  input  wire ctl_cmd_t             cmd_i,
  output ctl_sts_t                  sts_o,
  input  wire logic                 m_tready_i,
  output logic                      m_tvalid_o,
  output logic [M_TDATA_W-1:0]      m_tdata_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  // ---------------- histogram memory ----------------
  logic [NBINS-1:0] hist_vld_q;
  logic             hist_rvld_q;
  logic             hist_re;
  logic [BIN_W-1:0] hist_raddr;
  logic [CNT_W-1:0] hist_rdata;
  logic [CNT_W-1:0] hist_cur;
  logic [CNT_W-1:0] hist_new;
  logic [BIN_W-1:0] pix_q;

  // scan state
  logic [BIDX_W-1:0] scan_idx_q;
  logic              scan_pend_q;
  logic [BIN_W-1:0]  scan_at_q;
  logic              scan_rd;
  logic              hit;
  logic              found_q;
  logic [BIN_W-1:0]  lo_q, hi_q;
  logic [BIN_W-1:0]  span;

  assign scan_rd    = cmd_i.scan_step & ~scan_idx_q[BIDX_W-1];
  assign hist_re    = cmd_i.acc_rd | scan_rd;
  assign hist_raddr = cmd_i.acc_rd ? pixel_i : scan_idx_q[BIN_W-1:0];

  // saturating increment, unwritten bins read as zero
  assign hist_cur = hist_rvld_q ? hist_rdata : '0;
  assign hist_new = (hist_cur < CNT_MAX) ? hist_cur + CNT_W'(1) : hist_cur;

  hcs_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NBINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.acc_wr),
    .waddr_i (pix_q),
    .wdata_i (hist_new),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Bin valid bits: finish clears the whole histogram at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q  <= '0;
      hist_rvld_q <= 1'b0;
    end else begin
      if (cmd_i.fin_load) begin
        hist_vld_q <= '0;
      end else if (cmd_i.acc_wr) begin
        hist_vld_q[pix_q] <= 1'b1;
      end
      if (hist_re) begin
        hist_rvld_q <= hist_vld_q[hist_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_rd) begin
      pix_q <= pixel_i;
    end
  end

  // ---------------- bin scan ----------------
  assign hit = scan_pend_q & hist_rvld_q &
               (CMP_W'(hist_rdata) > CMP_W'(min_count_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      scan_pend_q <= 1'b0;
      found_q     <= 1'b0;
    end else if (cmd_i.fin_start) begin
      scan_idx_q  <= '0;
      scan_pend_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (scan_rd) begin
        scan_idx_q <= scan_idx_q + BIDX_W'(1);
      end
      scan_pend_q <= scan_rd;
      if (hit) begin
        found_q <= 1'b1;
      end
    end
  end

  // first hit sets low bound, every hit moves high bound
  always_ff @(posedge clk_i) begin
    if (scan_rd) begin
      scan_at_q <= scan_idx_q[BIN_W-1:0];
    end
    if (hit) begin
      hi_q <= scan_at_q;
      if (!found_q) begin
        lo_q <= scan_at_q;
      end
    end
  end

  assign span = hi_q - lo_q;

  // ---------------- 255 / span, one quotient bit per step ----------------
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [BIN_W-1:0]     div_q_q, div_rem_q;
  logic [BIN_W:0]       div_t;
  logic                 div_ge;

  assign div_t  = {div_rem_q, 1'b1};
  assign div_ge = (div_t >= {1'b0, span});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.fin_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_start) begin
      div_q_q   <= '0;
      div_rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q_q   <= {div_q_q[BIN_W-2:0], div_ge};
      div_rem_q <= div_ge ? BIN_W'(div_t - {1'b0, span}) : div_t[BIN_W-1:0];
    end
  end

  // ---------------- stretch table build ----------------
  // Running quotient/remainder of 255*(i-low)/span, advanced by 255/span.
  logic [BIDX_W-1:0] bld_idx_q;
  logic [BIN_W-1:0]  bld_i;
  logic [BIN_W-1:0]  acc_q_q, acc_r_q;
  logic [BIN_W:0]    r_sum;
  logic              r_wrap;
  logic [BIN_W:0]    twice;
  logic              round_up;
  logic              below, above;
  logic [PIX_W-1:0]  entry;
  logic              tbl_vld_q;
  logic [PIX_W-1:0]  tbl_rdata;

  assign bld_i    = bld_idx_q[BIN_W-1:0];
  assign below    = ~found_q | (bld_i < lo_q);
  assign above    = bld_i > hi_q;
  assign r_sum    = {1'b0, acc_r_q} + {1'b0, div_rem_q};
  assign r_wrap   = (r_sum >= {1'b0, span});
  assign twice    = {acc_r_q, 1'b0};
  assign round_up = (twice > {1'b0, span}) | ((twice == {1'b0, span}) & acc_q_q[0]);

  always_comb begin
    priority if (below) begin
      entry = '0;
    end else if (above) begin
      entry = TOPVAL;
    end else if (span == '0) begin
      entry = '0;
    end else begin
      entry = acc_q_q + PIX_W'(round_up);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bld_idx_q <= '0;
      tbl_vld_q <= 1'b0;
    end else if (cmd_i.fin_start) begin
      bld_idx_q <= '0;
    end else if (cmd_i.build_step) begin
      bld_idx_q <= bld_idx_q + BIDX_W'(1);
      if (bld_i == BIN_W'(NBINS - 1)) begin
        tbl_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_start) begin
      acc_q_q <= '0;
      acc_r_q <= '0;
    end else if (cmd_i.build_step && !below && !above) begin
      acc_q_q <= acc_q_q + div_q_q + BIN_W'(r_wrap);
      acc_r_q <= r_wrap ? BIN_W'(r_sum - {1'b0, span}) : r_sum[BIN_W-1:0];
    end
  end

  hcs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (NBINS)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.build_step),
    .waddr_i (bld_i),
    .wdata_i (entry),
    .re_i    (cmd_i.map_rd),
    .raddr_i (pixel_i),
    .rdata_o (tbl_rdata)
  );

  // ---------------- output register ----------------
  logic                  m_valid_q;
  logic [PIX_W-1:0]      out_pix_q;
  logic [BIDX_W-1:0]     out_lo_q, out_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.map_load || cmd_i.fin_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_load) begin
      out_pix_q <= tbl_vld_q ? tbl_rdata : '0;
      out_lo_q  <= '0;
      out_hi_q  <= '0;
    end else if (cmd_i.fin_load) begin
      out_pix_q <= '0;
      out_lo_q  <= found_q ? {1'b0, lo_q} : BIDX_W'(NBINS);
      out_hi_q  <= found_q ? {1'b0, hi_q} : '1;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(M_TDATA_W - PIX_W - 2 * BIDX_W){1'b0}}, out_hi_q, out_lo_q, out_pix_q};

  // ---------------- status ----------------
  assign sts_o.scan_done  = scan_idx_q[BIDX_W-1] & ~scan_pend_q;
  assign sts_o.div_last   = cmd_i.div_step & (div_cnt_q == '1);
  assign sts_o.build_last = cmd_i.build_step & (bld_i == BIN_W'(NBINS - 1));
  assign sts_o.out_free   = ~m_valid_q | m_tready_i;

endmodule

`default_nettype wire

>>> rtl/histogram_contrast_stretch_unit.sv
// Top level: stream ports, APB register for min_count, controller and datapath.
//
//  Port group  Dir  Fields (low bit first)
//  s_t*        in   tuser: cmd[1:0]; tdata: pixel[7:0]
//  m_t*        out  tdata: stretched_pixel[7:0], low_bin[16:8], high_bin[25:17], zero[31:26]
//  APB         in   min_count at byte address 0, 17 bits
//
//  Accumulate: bin read, then saturating write back.
//  Map: table read, then output load, which waits while the output register is still held by the sink.
//  Finish: accept, bin scan (256 reads, last compare, done check),
//  8 divider steps for 255/span, 256 table writes, 1 load (waits for a free output register).
//  Reset clears valid bits for bins and table; no clearing pass is needed.
//  A result waiting in the output register does not block accumulate items.
`timescale 1ns / 1ps
`default_nettype none

module histogram_contrast_stretch_unit
  import hcs_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [S_TDATA_W-1:0]  s_tdata_i,   // pixel[7:0]
  input  wire logic [CMD_W-1:0]      s_tuser_i,   // cmd[1:0]
  // result stream
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [M_TDATA_W-1:0]       m_tdata_o,   // stretched[7:0], low[16:8], high[25:17]
  // configuration
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic [APB_AW-1:0]     paddr_i,
  input  wire logic [APB_DW-1:0]     pwdata_i,
  output logic [APB_DW-1:0]          prdata_o,
  output logic                       pready_o
);

  logic [CFG_W-1:0] min_count_q;
  logic             cfg_wr;
  logic             reg_hit;
  ctl_cmd_t         ctl_cmd;
  ctl_sts_t         ctl_sts;

  // APB register access
  assign pready_o = 1'b1;
  assign reg_hit  = (paddr_i[APB_AW-1] == REG_MIN_COUNT);
  assign cfg_wr   = psel_i & penable_i & pwrite_i & reg_hit;
  assign prdata_o = reg_hit ? APB_DW'(min_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q <= '0;
    end else if (cfg_wr) begin
      min_count_q <= pwdata_i[CFG_W-1:0];
    end
  end

  hcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .cmd_i      (cmd_e'(s_tuser_i)),
    .s_tready_o (s_tready_o),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  hcs_dpath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (s_tdata_i[PIX_W-1:0]),
    .min_count_i (min_count_q),
    .cmd_i       (ctl_cmd),
    .sts_o       (ctl_sts),
    .m_tready_i  (m_tready_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tdata_o   (m_tdata_o)
  );

endmodule

`default_nettype wire

>>> dv/histogram_contrast_stretch_unit_test.sv
// Self-checking testbench for the histogram contrast stretch unit.
`timescale 1ns / 1ps

module histogram_contrast_stretch_unit_test;
  import hcs_pkg::*;

  localparam int unsigned MAX_PIXELS = 65536;
  localparam logic [APB_AW-1:0] MIN_COUNT_ADDR = {REG_MIN_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] UNUSED_ADDR    = {1'b1, 2'b00};  // word index 1, no register

  // One result beat, split into its fields
  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [BIDX_W-1:0] low;
    logic [BIDX_W-1:0] high;
  } stretch_beat_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed table
  typedef struct {
    row_kind_e         kind;
    cmd_e              cmd;
    logic [PIX_W-1:0]  pix;
    bit                typed;    // expectation written in the row
    logic [PIX_W-1:0]  e_pix;
    logic [BIDX_W-1:0] e_low;
    logic [BIDX_W-1:0] e_high;
    logic [APB_AW-1:0] addr;
    logic [CFG_W-1:0]  value;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid_i = 1'b0;
  logic                 s_tready_o;
  logic [S_TDATA_W-1:0] s_tdata_i = '0;    // pixel[7:0]
  logic [CMD_W-1:0]     s_tuser_i = '0;    // cmd[1:0]
  logic                 m_tvalid_o;
  logic                 m_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata_o;         // stretched[7:0], low[16:8], high[25:17], zero[31:26]
  logic                 psel_i = 1'b0;
  logic                 penable_i = 1'b0;
  logic                 pwrite_i = 1'b0;
  logic [APB_AW-1:0]    paddr_i = '0;
  logic [APB_DW-1:0]    pwdata_i = '0;
  logic [APB_DW-1:0]    prdata_o;
  logic                 pready_o;

  // Predictor state
  logic [CFG_W-1:0]     model_bins [NBINS];
  logic [PIX_W-1:0]     model_lut [NBINS];
  logic [CFG_W-1:0]     model_min_count;

  stretch_beat_t        expected_beats [$];
  dir_row_t             dir_rows [$];
  int                   fail_count = 0;
  int                   src_idle = 0;   // percent of cycles the sender holds off
  int                   snk_idle = 0;   // percent of cycles the receiver stalls

  histogram_contrast_stretch_unit #(.MAX_PIXELS(MAX_PIXELS)) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // Histogram, bound search and stretch table; returns 1 when the item yields a beat
  function automatic bit stretch_model_step(input cmd_e c, input logic [PIX_W-1:0] px,
                                            output stretch_beat_t r);
    int lo;
    int hi;
    int den;
    int num;
    int q;
    int rem;
    r = '0;
    case (c)
      CMD_ACC: begin
        if (model_bins[px] < CFG_W'(MAX_PIXELS)) model_bins[px] = model_bins[px] + 1'b1;
        return 1'b0;
      end
      CMD_FIN: begin
        lo = 0;
        while (lo < int'(NBINS) && !(model_bins[lo] > model_min_count)) lo++;
        hi = int'(NBINS) - 1;
        while (hi >= 0 && !(model_bins[hi] > model_min_count)) hi--;
        for (int i = 0; i < int'(NBINS); i++) begin
          if (i < lo) begin
            model_lut[i] = '0;
          end else if (i > hi) begin
            model_lut[i] = TOPVAL;
          end else begin
            den = hi - lo;
            if (den == 0) begin
              model_lut[i] = '0;
            end else begin
              // round to nearest, ties to even
              num = int'(TOPVAL) * (i - lo);
              q   = num / den;
              rem = num % den;
              if (2 * rem > den || (2 * rem == den && q[0])) q++;
              model_lut[i] = PIX_W'(q);
            end
          end
        end
        for (int i = 0; i < int'(NBINS); i++) model_bins[i] = '0;
        r.low  = BIDX_W'(lo);
        r.high = BIDX_W'(hi);
        return 1'b1;
      end
      CMD_MAP: begin
        r.pix = model_lut[px];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offer one input beat, wait for acceptance, then record what it should produce
  task automatic push_item(input cmd_e c, input logic [PIX_W-1:0] px, input bit typed = 1'b0,
                           input logic [PIX_W-1:0] e_pix = '0,
                           input logic [BIDX_W-1:0] e_low = '0,
                           input logic [BIDX_W-1:0] e_high = '0);
    stretch_beat_t r;
    bit            has_beat;
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= c;
    s_tdata_i  <= px;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    has_beat = stretch_model_step(c, px, r);
    if (has_beat) begin
      if (typed) r = '{pix: e_pix, low: e_low, high: e_high};
      expected_beats.push_back(r);
    end
  endtask

  // Stop sending and let every pending beat and accumulate settle
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write, then read min_count back; upper data bits carry junk
  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] junk;
    junk = $urandom;
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= addr;
    pwdata_i  <= {junk[APB_DW-1:CFG_W], value};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    if (addr == MIN_COUNT_ADDR) model_min_count = value;
    pwrite_i  <= 1'b0;
    penable_i <= 1'b0;
    paddr_i   <= MIN_COUNT_ADDR;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    if (prdata_o[CFG_W-1:0] !== model_min_count) begin
      $error("min_count readback: expected %0d, actual %0d", model_min_count,
             prdata_o[CFG_W-1:0]);
      fail_count++;
    end
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void add_item(input cmd_e c, input logic [PIX_W-1:0] px,
                                   input bit typed = 1'b0,
                                   input logic [PIX_W-1:0] e_pix = '0,
                                   input logic [BIDX_W-1:0] e_low = '0,
                                   input logic [BIDX_W-1:0] e_high = '0);
    dir_row_t row;
    row = '{kind: ROW_ITEM, cmd: c, pix: px, typed: typed, e_pix: e_pix, e_low: e_low,
            e_high: e_high, addr: '0, value: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] value);
    dir_row_t row;
    row = '{kind: ROW_CFG, cmd: CMD_ACC, pix: '0, typed: 1'b0, e_pix: '0, e_low: '0,
            e_high: '0, addr: addr, value: value};
    dir_rows.push_back(row);
  endfunction

  // Random sequences: accumulate a clustered burst, finish, then map
  task automatic random_phase(input int src_pct, input int snk_pct, input int quota);
    int               done_items;
    int               n_acc;
    int               n_map;
    int               base;
    int               span;
    int               pick;
    logic [PIX_W-1:0] px;
    cmd_e             c;
    src_idle   = src_pct;
    snk_idle   = snk_pct;
    done_items = 0;
    while (done_items < quota) begin
      // new threshold now and then, including both extremes
      pick = $urandom_range(0, 11);
      if (pick < 3) begin
        wait_idle();
        case (pick)
          0: cfg_write(MIN_COUNT_ADDR, CFG_W'($urandom_range(0, 3)));
          1: cfg_write(MIN_COUNT_ADDR, ($urandom_range(0, 1) != 0) ? CFG_W'(0)
                                                                    : CFG_W'(MAX_PIXELS));
          default: cfg_write(MIN_COUNT_ADDR, CFG_W'($urandom_range(0, MAX_PIXELS)));
        endcase
      end else if (pick == 3) begin
        wait_idle();
      end
      n_acc = $urandom_range(0, 40);
      base  = $urandom_range(0, 255);
      span  = $urandom_range(0, 24);
      for (int k = 0; k < n_acc; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          c  = cmd_e'($urandom_range(0, 3));
          px = PIX_W'($urandom);
          push_item(c, px);
          if (c != CMD_RSV) done_items++;
        end
        if ($urandom_range(0, 7) == 0) px = PIX_W'($urandom);
        else px = PIX_W'(base + $urandom_range(0, span));
        push_item(CMD_ACC, px);
        done_items++;
      end
      // a few sequences skip the finish on purpose
      if ($urandom_range(0, 9) != 0) begin
        push_item(CMD_FIN, PIX_W'($urandom));
        done_items++;
      end
      n_map = $urandom_range(1, 10);
      for (int k = 0; k < n_map; k++) begin
        if ($urandom_range(0, 1) != 0) px = PIX_W'($urandom);
        else px = PIX_W'(base + $urandom_range(0, span));
        push_item(CMD_MAP, px);
        done_items++;
      end
    end
  endtask

  // Sink: check each accepted beat and draw the next tready
  always @(posedge clk_i) begin : sink
    stretch_beat_t want;
    if (m_tvalid_o && m_tready_i) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_tdata_o);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (m_tdata_o[7:0] !== want.pix) begin
          $error("stretched_pixel: expected %0d, actual %0d", want.pix, m_tdata_o[7:0]);
          fail_count++;
        end
        if (m_tdata_o[16:8] !== want.low) begin
          $error("low_bin: expected %0d, actual %0d", want.low, m_tdata_o[16:8]);
          fail_count++;
        end
        if (m_tdata_o[25:17] !== want.high) begin
          $error("high_bin: expected %h, actual %h", want.high, m_tdata_o[25:17]);
          fail_count++;
        end
        if (m_tdata_o[31:26] !== '0) begin
          $error("tdata padding: expected 0, actual %h", m_tdata_o[31:26]);
          fail_count++;
        end
      end
    end
    if (rst_ni) m_tready_i <= ($urandom_range(0, 99) >= snk_idle);
  end

  // Main sequence
  initial begin
    for (int i = 0; i < int'(NBINS); i++) begin
      model_bins[i] = '0;
      model_lut[i]  = '0;
    end
    model_min_count = '0;

    // Directed table; rows with written results are the obvious ones
    add_item(CMD_MAP, 8'd0,   1'b1, 8'd0, 9'd0, 9'd0);      // table empty after reset
    add_item(CMD_MAP, 8'd255, 1'b1, 8'd0, 9'd0, 9'd0);
    add_item(CMD_FIN, 8'd0,   1'b1, 8'd0, 9'd256, 9'h1FF);  // no bin above threshold
    add_item(CMD_RSV, 8'hFF);                                // ignored command
    add_item(CMD_ACC, 8'd0);
    add_item(CMD_ACC, 8'd255);
    add_item(CMD_FIN, 8'hFF,  1'b1, 8'd0, 9'd0, 9'd255);    // full range
    add_item(CMD_MAP, 8'd255, 1'b1, 8'd255, 9'd0, 9'd0);
    add_item(CMD_MAP, 8'd128);
    add_item(CMD_ACC, 8'd100);
    add_item(CMD_FIN, 8'd0,   1'b1, 8'd0, 9'd100, 9'd100);  // single bin
    add_item(CMD_MAP, 8'd100, 1'b1, 8'd0, 9'd0, 9'd0);
    add_item(CMD_MAP, 8'd101, 1'b1, 8'd255, 9'd0, 9'd0);
    add_item(CMD_ACC, 8'd10);
    add_item(CMD_ACC, 8'd16);
    add_item(CMD_FIN, 8'd0,   1'b1, 8'd0, 9'd10, 9'd16);
    add_item(CMD_MAP, 8'd11);                                // exact tie, rounds down to even
    add_item(CMD_MAP, 8'd13);                                // exact tie, rounds up to even
    add_cfg(UNUSED_ADDR, 17'h1FFFF);                         // no register there
    add_cfg(MIN_COUNT_ADDR, CFG_W'(MAX_PIXELS));
    add_item(CMD_ACC, 8'd7);
    add_item(CMD_FIN, 8'd0,   1'b1, 8'd0, 9'd256, 9'h1FF);
    add_cfg(MIN_COUNT_ADDR, 17'd1);
    add_item(CMD_ACC, 8'd3);
    add_item(CMD_ACC, 8'd3);
    add_item(CMD_ACC, 8'd4);                                 // count 1 does not exceed 1
    add_item(CMD_FIN, 8'd0,   1'b1, 8'd0, 9'd3, 9'd3);
    add_item(CMD_MAP, 8'd200, 1'b1, 8'd255, 9'd0, 9'd0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle = 25;
    snk_idle = 85;
    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_rows[n].addr, dir_rows[n].value);
      end else begin
        push_item(dir_rows[n].cmd, dir_rows[n].pix, dir_rows[n].typed, dir_rows[n].e_pix,
                  dir_rows[n].e_low, dir_rows[n].e_high);
      end
    end

    random_phase(25, 85, 170);
    random_phase(85, 25, 170);
    random_phase(0, 0, 170);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hcs_pkg.sv
rtl/hcs_ram.sv
rtl/hcs_ctrl.sv
rtl/hcs_dpath.sv
rtl/histogram_contrast_stretch_unit.sv
dv/histogram_contrast_stretch_unit_test.sv
